// ===== rtl/drl_pkg.sv =====
// Shared types and constants for the data run list decoder.
`default_nettype none
package drl_pkg;

  localparam logic [3:0] MaxFieldBytes = 4'd8;

  typedef enum logic [1:0] {
    KindRun    = 2'd0,
    KindSparse = 2'd1,
    KindEnd    = 2'd2,
    KindError  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhHeader = 2'd1,
    PhLength = 2'd2,
    PhOffset = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic        start;
    logic        clr_prev;
    logic [63:0] offset;
    logic [63:0] length;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/drl_front.sv =====
// Front end: parses list bytes into run commands.
`default_nettype none
module drl_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          list_start_i,
  input  wire logic          extent_i,
  output drl_pkg::cmd_t      cmd_o,
  output logic               cmd_valid_o
);

  drl_pkg::phase_e phase_q, phase_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [3:0]  off_left_q, off_left_d;
  logic [2:0]  pos_q, pos_d;
  logic [63:0] len_acc_q, len_acc_d;
  logic [63:0] off_acc_q, off_acc_d;
  logic        pend_start_q, pend_start_d;
  logic        pend_clr_q, pend_clr_d;

  drl_pkg::phase_e phase_eff;
  logic            start_eff;
  logic            clr_eff;
  logic [3:0]      len_n;
  logic [3:0]      off_n;
  logic [3:0]      left_dec;
  logic [63:0]     off_final;
  drl_pkg::kind_e  kind_c;
  logic            emit_c;

  assign len_n = data_byte_i[3:0];
  assign off_n = data_byte_i[7:4];

  always_comb begin
    phase_eff = list_start_i ? drl_pkg::PhHeader : phase_q;
    start_eff = pend_start_q | list_start_i;
    clr_eff   = pend_clr_q | (list_start_i & ~extent_i);

    phase_d      = phase_q;
    len_left_d   = len_left_q;
    off_left_d   = off_left_q;
    pos_d        = pos_q;
    len_acc_d    = len_acc_q;
    off_acc_d    = off_acc_q;
    pend_start_d = pend_start_q;
    pend_clr_d   = pend_clr_q;
    kind_c       = drl_pkg::KindRun;
    emit_c       = 1'b0;
    left_dec     = 4'd0;
    off_final    = off_acc_q;

    if (accept_i) begin
      pend_start_d = start_eff;
      pend_clr_d   = clr_eff;
      phase_d      = phase_eff;
      case (phase_eff)
        drl_pkg::PhIdle: begin
        end
        drl_pkg::PhHeader: begin
          if (data_byte_i == 8'd0) begin
            kind_c  = drl_pkg::KindEnd;
            emit_c  = 1'b1;
            phase_d = drl_pkg::PhIdle;
          end else if (len_n > drl_pkg::MaxFieldBytes || off_n > drl_pkg::MaxFieldBytes) begin
            kind_c  = drl_pkg::KindError;
            emit_c  = 1'b1;
            phase_d = drl_pkg::PhIdle;
          end else begin
            len_left_d = len_n;
            off_left_d = off_n;
            pos_d      = 3'd0;
            len_acc_d  = 64'd0;
            off_acc_d  = 64'd0;
            phase_d    = (len_n != 4'd0) ? drl_pkg::PhLength : drl_pkg::PhOffset;
          end
        end
        drl_pkg::PhLength: begin
          len_acc_d[{pos_q, 3'b000} +: 8] = data_byte_i;
          pos_d      = pos_q + 3'd1;
          left_dec   = len_left_q - 4'd1;
          len_left_d = left_dec;
          if (left_dec == 4'd0) begin
            pos_d = 3'd0;
            if (off_left_q == 4'd0) begin
              kind_c  = drl_pkg::KindSparse;
              emit_c  = 1'b1;
              phase_d = drl_pkg::PhHeader;
            end else begin
              phase_d = drl_pkg::PhOffset;
            end
          end
        end
        drl_pkg::PhOffset: begin
          off_acc_d[{pos_q, 3'b000} +: 8] = data_byte_i;
          left_dec   = off_left_q - 4'd1;
          off_left_d = left_dec;
          if (left_dec != 4'd0) begin
            pos_d = pos_q + 3'd1;
          end else begin
            for (int i = 0; i < 8; i++) begin
              if (3'(i) < pos_q) begin
                off_final[i*8 +: 8] = off_acc_q[i*8 +: 8];
              end else if (3'(i) == pos_q) begin
                off_final[i*8 +: 8] = data_byte_i;
              end else begin
                off_final[i*8 +: 8] = {8{data_byte_i[7]}};
              end
            end
            off_acc_d = off_final;
            kind_c    = drl_pkg::KindRun;
            emit_c    = 1'b1;
            pos_d     = 3'd0;
            phase_d   = drl_pkg::PhHeader;
          end
        end
        default: begin
          phase_d = drl_pkg::PhIdle;
        end
      endcase
      if (emit_c) begin
        pend_start_d = 1'b0;
        pend_clr_d   = 1'b0;
      end
    end
  end

  assign cmd_valid_o     = emit_c;
  assign cmd_o.kind      = kind_c;
  assign cmd_o.start     = start_eff;
  assign cmd_o.clr_prev  = clr_eff;
  assign cmd_o.offset    = off_final;
  assign cmd_o.length    = len_acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= drl_pkg::PhIdle;
      len_left_q   <= 4'd0;
      off_left_q   <= 4'd0;
      pos_q        <= 3'd0;
      pend_start_q <= 1'b0;
      pend_clr_q   <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      len_left_q   <= len_left_d;
      off_left_q   <= off_left_d;
      pos_q        <= pos_d;
      pend_start_q <= pend_start_d;
      pend_clr_q   <= pend_clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_acc_q <= len_acc_d;
    off_acc_q <= off_acc_d;
  end

endmodule
`default_nettype wire

// ===== rtl/drl_fifo.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
module drl_fifo #(
  parameter int Depth = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  drl_pkg::cmd_t      data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output drl_pkg::cmd_t      data_o,
  output logic               valid_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  drl_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/drl_back.sv =====
// Back end: cluster arithmetic, fragment count and result register.
`default_nettype none
module drl_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  drl_pkg::cmd_t      cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  output logic [1:0]         kind_o,
  output logic [63:0]        run_cluster_o,
  output logic [63:0]        run_length_o,
  output logic [15:0]        fragment_count_o,
  output logic               out_valid_o,
  input  wire logic          out_pop_i
);

  logic [63:0] cur_q, cur_d;
  logic [63:0] prev_c_q, prev_c_d;
  logic [63:0] prev_l_q, prev_l_d;
  logic [15:0] frag_q, frag_d;
  logic        out_valid_q, out_valid_d;
  drl_pkg::kind_e out_kind_q, out_kind_d;
  logic [63:0] out_cluster_q, out_cluster_d;
  logic [63:0] out_length_q, out_length_d;
  logic [15:0] out_frag_q, out_frag_d;

  logic [63:0] cur_b, pc_b, pl_b, new_c, prev_end;
  logic [15:0] frag_b;
  logic        take;

  assign take      = cmd_valid_i & (~out_valid_q | out_pop_i);
  assign cmd_pop_o = take;

  always_comb begin
    cur_b    = cmd_i.start ? 64'd0 : cur_q;
    frag_b   = cmd_i.start ? 16'd0 : frag_q;
    pc_b     = cmd_i.clr_prev ? 64'd0 : prev_c_q;
    pl_b     = cmd_i.clr_prev ? 64'd0 : prev_l_q;
    new_c    = cur_b + cmd_i.offset;
    prev_end = pc_b + pl_b;

    cur_d         = cur_q;
    prev_c_d      = prev_c_q;
    prev_l_d      = prev_l_q;
    frag_d        = frag_q;
    out_valid_d   = out_valid_q & ~out_pop_i;
    out_kind_d    = out_kind_q;
    out_cluster_d = out_cluster_q;
    out_length_d  = out_length_q;
    out_frag_d    = out_frag_q;

    if (take) begin
      cur_d         = cur_b;
      prev_c_d      = pc_b;
      prev_l_d      = pl_b;
      frag_d        = frag_b;
      out_valid_d   = 1'b1;
      out_kind_d    = cmd_i.kind;
      out_cluster_d = 64'd0;
      out_length_d  = 64'd0;
      case (cmd_i.kind)
        drl_pkg::KindRun: begin
          cur_d    = new_c;
          prev_c_d = new_c;
          prev_l_d = cmd_i.length;
          if (prev_end != new_c && frag_b != 16'hFFFF) begin
            frag_d = frag_b + 16'd1;
          end
          out_cluster_d = new_c;
          out_length_d  = cmd_i.length;
        end
        drl_pkg::KindSparse: begin
          out_length_d = cmd_i.length;
        end
        default: begin
        end
      endcase
      out_frag_d = frag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= 64'd0;
      prev_c_q    <= 64'd0;
      prev_l_q    <= 64'd0;
      frag_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      prev_c_q    <= prev_c_d;
      prev_l_q    <= prev_l_d;
      frag_q      <= frag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q    <= out_kind_d;
    out_cluster_q <= out_cluster_d;
    out_length_q  <= out_length_d;
    out_frag_q    <= out_frag_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_kind_q;
  assign run_cluster_o    = out_cluster_q;
  assign run_length_o     = out_length_q;
  assign fragment_count_o = out_frag_q;

endmodule
`default_nettype wire

// ===== rtl/data_run_list_decoder.sv =====
// Data run list decoder top level: front parser, command queue, back end.
// Throughput: one list byte per cycle, sustained, while results are popped.
// A result reaches the result ports through a command queue entry, then the back
// end result register, after the byte that completes it is accepted.
// Reset: asynchronous, active low; clears the parser phase, queue, running
// cluster, previous run and fragment count. No clearing pass is needed.
`default_nettype none
module data_run_list_decoder #(
  parameter int QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        list_start_i,
  input  wire logic        extent_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind_o,
  output logic [63:0]      run_cluster_o,
  output logic [63:0]      run_length_o,
  output logic [15:0]      fragment_count_o
);

  drl_pkg::cmd_t front_cmd;
  drl_pkg::cmd_t back_cmd;
  logic          front_valid;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          out_valid;
  logic          accept;

  assign full   = q_full;
  assign accept = push & ~q_full;
  assign empty  = ~out_valid;

  drl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .list_start_i (list_start_i),
    .extent_i     (extent_i),
    .cmd_o        (front_cmd),
    .cmd_valid_o  (front_valid)
  );

  drl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (back_cmd),
    .valid_o (q_valid)
  );

  drl_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (back_cmd),
    .cmd_valid_i      (q_valid),
    .cmd_pop_o        (q_pop),
    .kind_o           (kind_o),
    .run_cluster_o    (run_cluster_o),
    .run_length_o     (run_length_o),
    .fragment_count_o (fragment_count_o),
    .out_valid_o      (out_valid),
    .out_pop_i        (pop)
  );

endmodule
`default_nettype wire

// ===== dv/data_run_list_decoder_test.sv =====
// Self-checking testbench for the data run list decoder: directed and random run lists.
`default_nettype none
module data_run_list_decoder_test;

  localparam int HoldCycles = 400;
  localparam int QuietLimit = 3000;
  localparam int RandomBytes = 800;

  typedef struct {
    drl_pkg::kind_e kind;
    logic [63:0]    cluster;
    logic [63:0]    length;
    logic [15:0]    frags;
  } run_word_t;

  class run_list_tracker;
    run_word_t       runs_due[$];
    int unsigned     errors;
    drl_pkg::phase_e phase;
    logic [3:0]      len_left;
    logic [3:0]      off_left;
    logic [2:0]      pos;
    logic [63:0]     len_acc;
    logic [63:0]     off_acc;
    logic [63:0]     cluster;
    logic [63:0]     prev_cluster;
    logic [63:0]     prev_length;
    logic [15:0]     frags;

    function new();
      errors = 0;
      phase = drl_pkg::PhIdle;
      len_left = '0;
      off_left = '0;
      pos = '0;
      len_acc = '0;
      off_acc = '0;
      cluster = '0;
      prev_cluster = '0;
      prev_length = '0;
      frags = '0;
    endfunction

    function void add_due(drl_pkg::kind_e k, logic [63:0] c, logic [63:0] l);
      run_word_t w;
      w.kind = k;
      w.cluster = c;
      w.length = l;
      w.frags = frags;
      runs_due.push_back(w);
    endfunction

    function int unsigned outstanding();
      return runs_due.size();
    endfunction

    // Offset that makes the next run start where the previous run ended.
    function logic [63:0] contiguous_offset();
      return prev_cluster + prev_length - cluster;
    endfunction

    function void decode_byte(logic [7:0] b, logic st, logic ex);
      logic [2:0] at;
      if (st) begin
        cluster = '0;
        frags = '0;
        if (!ex) begin
          prev_cluster = '0;
          prev_length = '0;
        end
        phase = drl_pkg::PhHeader;
      end
      case (phase)
        drl_pkg::PhIdle: ;
        drl_pkg::PhHeader: begin
          if (b == 8'h00) begin
            phase = drl_pkg::PhIdle;
            add_due(drl_pkg::KindEnd, '0, '0);
          end else if (b[3:0] > drl_pkg::MaxFieldBytes ||
                       b[7:4] > drl_pkg::MaxFieldBytes) begin
            phase = drl_pkg::PhIdle;
            add_due(drl_pkg::KindError, '0, '0);
          end else begin
            len_left = b[3:0];
            off_left = b[7:4];
            pos = '0;
            len_acc = '0;
            off_acc = '0;
            phase = (b[3:0] != 4'd0) ? drl_pkg::PhLength : drl_pkg::PhOffset;
          end
        end
        drl_pkg::PhLength: begin
          len_acc |= {56'd0, b} << (pos * 8);
          pos++;
          len_left--;
          if (len_left == 4'd0) begin
            pos = '0;
            if (off_left == 4'd0) begin
              phase = drl_pkg::PhHeader;
              add_due(drl_pkg::KindSparse, '0, len_acc);
            end else begin
              phase = drl_pkg::PhOffset;
            end
          end
        end
        drl_pkg::PhOffset: begin
          at = pos;
          off_acc |= {56'd0, b} << (at * 8);
          off_left--;
          if (off_left != 4'd0) begin
            pos = at + 3'd1;
          end else begin
            // sign-extend from the last offset byte
            if (b[7] && at != 3'd7) off_acc |= {64{1'b1}} << ((at + 1) * 8);
            cluster += off_acc;
            if (prev_cluster + prev_length != cluster && frags != 16'hFFFF) frags++;
            prev_cluster = cluster;
            prev_length = len_acc;
            pos = '0;
            phase = drl_pkg::PhHeader;
            add_due(drl_pkg::KindRun, cluster, len_acc);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    endfunction

    function void check_run(logic [1:0] k, logic [63:0] c, logic [63:0] l, logic [15:0] f);
      run_word_t w;
      if (runs_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual kind %0d cluster %0h",
                 $time, k, c);
        return;
      end
      w = runs_due.pop_front();
      if (k !== w.kind) report("kind", w.kind, k);
      if (c !== w.cluster) report("run_cluster", w.cluster, c);
      if (l !== w.length) report("run_length", w.length, l);
      if (f !== w.frags) report("fragment_count", w.frags, f);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        list_start_i = 1'b0;
  logic        extent_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind_o;
  logic [63:0] run_cluster_o;
  logic [63:0] run_length_o;
  logic [15:0] fragment_count_o;

  run_list_tracker tracker;
  int  burst_left = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  list_bytes = 0;
  bit  next_start = 1'b0;
  bit  next_ext = 1'b0;
  int  quiet_cycles = 0;

  data_run_list_decoder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .list_start_i     (list_start_i),
    .extent_i         (extent_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (kind_o),
    .run_cluster_o    (run_cluster_o),
    .run_length_o     (run_length_o),
    .fragment_count_o (fragment_count_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("Verification failed");
    $finish;
  end

  // Drain results; stall on a rotating pattern or hold off on request.
  initial begin
    logic [15:0] stall_pat;
    logic [5:0]  pat_age;
    stall_pat = '1;
    pat_age = '0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty)
        tracker.check_run(kind_o, run_cluster_o, run_length_o, fragment_count_o);
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        pop <= 1'b0;
      end else begin
        if (pat_age == 6'd0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = '1;
            1: stall_pat = 16'($urandom);
            2: stall_pat = 16'($urandom | $urandom);
            default: stall_pat = 16'($urandom & $urandom);
          endcase
        end
        pat_age++;
        pop <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st, input logic ex);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    push <= 1'b1;
    data_byte_i <= b;
    list_start_i <= st;
    extent_i <= ex;
    do @(posedge clk_i); while (full);
    tracker.decode_byte(b, st, ex);
  endtask

  task automatic list_byte(input logic [7:0] b);
    send_byte(b, next_start, next_ext);
    next_start = 1'b0;
    list_bytes++;
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  task automatic send_run();
    int len_n;
    int off_n;
    bit contig;
    logic [63:0] off_val;
    logic [7:0] hdr;
    len_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 2);
    contig = ($urandom_range(0, 3) == 0);
    if (contig) off_n = 8;
    else if ($urandom_range(0, 4) == 0) off_n = 0;
    else off_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
    if (len_n == 0 && off_n == 0) len_n = 1;
    hdr = {off_n[3:0], len_n[3:0]};
    list_byte(hdr);
    for (int i = 0; i < len_n; i++)
      list_byte(($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom));
    if (contig) off_val = tracker.contiguous_offset();
    else off_val = {$urandom, $urandom};
    for (int i = 0; i < off_n; i++) list_byte(off_val[8 * i +: 8]);
  endtask

  task automatic send_list(input logic ex, input int runs);
    logic [3:0] bad;
    next_start = 1'b1;
    next_ext = ex;
    repeat (runs) send_run();
    bad = 4'($urandom_range(9, 15));
    case ($urandom_range(0, 7))
      0: begin
        // abandon a partial run; the next list start cuts it off
        list_byte(8'h13);
        list_byte(8'($urandom));
      end
      1: list_byte(($urandom_range(0, 1) == 0) ? {bad, 4'($urandom)} : {4'($urandom), bad});
      default: list_byte(8'h00);
    endcase
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
    if ($urandom_range(0, 15) == 0)
      repeat ($urandom_range(1, 12))
        send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'($urandom));
  endtask

  initial begin
    bit hold_done;
    bit drain_done;
    tracker = new();
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte while idle, ignored
    send_byte(8'hA5, 1'b0, 1'b0);
    // negative offset wraps the cluster
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    // zero-length run
    send_byte(8'h10, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    // sparse run, then end of list
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h05, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // oversized length and offset fields
    send_byte(8'h09, 1'b1, 1'b1);
    send_byte(8'hF1, 1'b1, 1'b0);
    // full-width offset, no sign extension
    send_byte(8'h81, 1'b1, 1'b1);
    send_byte(8'h10, 1'b0, 1'b0);
    for (int i = 1; i < 8; i++) send_byte(8'(i), 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    // list start in the middle of a run
    send_byte(8'h22, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
    wait_for_results();

    list_bytes = 0;
    while (list_bytes < RandomBytes) begin
      if (!hold_done && list_bytes > 250) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && list_bytes > 500) begin
        wait_for_results();
        drain_done = 1'b1;
      end
      send_list(1'($urandom), $urandom_range(1, 6));
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/drl_pkg.sv
rtl/drl_front.sv
rtl/drl_fifo.sv
rtl/drl_back.sv
rtl/data_run_list_decoder.sv
dv/data_run_list_decoder_test.sv
